// ===== hdl/rjag_pkg.sv =====
// Shared types, constants and the constant logarithm for the job attribute generator.
`timescale 1ns / 1ps
package rjag_pkg;

	localparam logic [14:0] PM_MULT    = 15'd16807;
	localparam logic [30:0] PM_MOD     = 31'h7FFF_FFFF;
	localparam logic [30:0] SEED_RESET = 31'd56329;
	localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
	localparam logic [4:0]  EXP_TOP    = 5'd30;

	localparam logic [1:0] REG_MEAN = 2'd0;
	localparam logic [1:0] REG_MAX  = 2'd1;
	localparam logic [1:0] REG_MIN  = 2'd2;
	localparam logic [1:0] REG_SEED = 2'd3;

	typedef enum logic [14:0] {
		ST_IDLE = 15'b000000000000001,
		ST_MUL  = 15'b000000000000010,
		ST_RED  = 15'b000000000000100,
		ST_PRIO = 15'b000000000001000,
		ST_NORM = 15'b000000000010000,
		ST_SQR  = 15'b000000000100000,
		ST_DIFF = 15'b000000001000000,
		ST_LNLO = 15'b000000010000000,
		ST_LNHI = 15'b000000100000000,
		ST_NL   = 15'b000001000000000,
		ST_GAP  = 15'b000010000000000,
		ST_ARR  = 15'b000100000000000,
		ST_BMUL = 15'b001000000000000,
		ST_BRED = 15'b010000000000000,
		ST_DONE = 15'b100000000000000
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic       pm_mul;
		logic       pm_red;
		logic [1:0] draw;
		logic       prio;
		logic       norm;
		logic       sqr;
		logic       diff;
		logic       lnlo;
		logic       lnhi;
		logic       nl;
		logic       gap;
		logic       arr;
		logic       bmul;
		logic       bred;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic s2_zero;
		logic x_top;
	} sts_t;

	function automatic logic [63:0] log2_mod(input int frac);
		logic [63:0] x;
		logic [63:0] r;
		x = 64'h7FFF_FFFF;
		r = 64'd30 << frac;
		for (int i = 31; i >= 0; i--) begin
			if (i < frac) begin
				x = (x * x) >> 30;
				if (x >= 64'h8000_0000) begin
					r = r | (64'd1 << i);
					x = x >> 1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/rjag_ctrl.sv =====
// Sequencer for the job attribute generator: draws, logarithm loop, output handshake.
`timescale 1ns / 1ps
module rjag_ctrl #(
	parameter int LN_FRAC_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  rjag_pkg::sts_t  sts,
	output rjag_pkg::cmd_t  cmd
);

	localparam int CW = (LN_FRAC_BITS > 1) ? $clog2(LN_FRAC_BITS) : 1;

	rjag_pkg::state_t state_q, state_d;
	logic [1:0]       draw_q, draw_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             m_tvalid_q;

	assign s_tready = (state_q == rjag_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		draw_d  = draw_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.draw = draw_q;
		unique case (state_q)
			rjag_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					draw_d      = 2'd0;
					state_d     = rjag_pkg::ST_MUL;
				end
			end
			rjag_pkg::ST_MUL: begin
				cmd.pm_mul = 1'b1;
				state_d    = rjag_pkg::ST_RED;
			end
			rjag_pkg::ST_RED: begin
				cmd.pm_red = 1'b1;
				if (draw_q == 2'd2) begin
					state_d = rjag_pkg::ST_PRIO;
				end else begin
					draw_d  = draw_q + 2'd1;
					state_d = rjag_pkg::ST_MUL;
				end
			end
			rjag_pkg::ST_PRIO: begin
				cmd.prio = 1'b1;
				state_d  = sts.s2_zero ? rjag_pkg::ST_ARR : rjag_pkg::ST_NORM;
			end
			rjag_pkg::ST_NORM: begin
				cmd.norm = 1'b1;
				if (sts.x_top) begin
					cnt_d   = CW'(LN_FRAC_BITS - 1);
					state_d = rjag_pkg::ST_SQR;
				end
			end
			rjag_pkg::ST_SQR: begin
				cmd.sqr = 1'b1;
				if (cnt_q == '0) begin
					state_d = rjag_pkg::ST_DIFF;
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			rjag_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = rjag_pkg::ST_LNLO;
			end
			rjag_pkg::ST_LNLO: begin
				cmd.lnlo = 1'b1;
				state_d  = rjag_pkg::ST_LNHI;
			end
			rjag_pkg::ST_LNHI: begin
				cmd.lnhi = 1'b1;
				state_d  = rjag_pkg::ST_NL;
			end
			rjag_pkg::ST_NL: begin
				cmd.nl  = 1'b1;
				state_d = rjag_pkg::ST_GAP;
			end
			rjag_pkg::ST_GAP: begin
				cmd.gap = 1'b1;
				state_d = rjag_pkg::ST_ARR;
			end
			rjag_pkg::ST_ARR: begin
				cmd.arr = 1'b1;
				state_d = rjag_pkg::ST_BMUL;
			end
			rjag_pkg::ST_BMUL: begin
				cmd.bmul = 1'b1;
				state_d  = rjag_pkg::ST_BRED;
			end
			rjag_pkg::ST_BRED: begin
				cmd.bred = 1'b1;
				state_d  = rjag_pkg::ST_DONE;
			end
			rjag_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = rjag_pkg::ST_IDLE;
				end
			end
			default: state_d = rjag_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rjag_pkg::ST_IDLE;
			draw_q     <= 2'd0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			draw_q  <= draw_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/rjag_dp.sv =====
// Datapath: configuration registers, generator, logarithm, scaling and result registers.
`timescale 1ns / 1ps
module rjag_dp #(
	parameter int LN_FRAC_BITS = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_addr,
	input  logic [30:0]    cfg_data,
	input  logic [31:0]    previous_arrival,
	input  rjag_pkg::cmd_t cmd,
	output rjag_pkg::sts_t sts,
	output logic [3:0]     job_priority,
	output logic [31:0]    job_arrival,
	output logic [15:0]    job_burst
);

	localparam int F   = LN_FRAC_BITS;
	localparam int RW  = F + 5;
	localparam int HW  = RW - 16;
	localparam int PHW = HW + 32;
	localparam int SW  = RW + 17;
	localparam int GMW = RW + 16;
	localparam int GSW = GMW + 1;
	localparam int GW  = GSW - F;
	localparam logic [63:0]   LM_FULL = rjag_pkg::log2_mod(LN_FRAC_BITS);
	localparam logic [RW-1:0] LM      = LM_FULL[RW-1:0];
	localparam logic [GSW-1:0] HALF   = GSW'(1) << (F - 1);

	logic [15:0]  mean_q, max_q, min_q;
	logic [30:0]  gen_q, s1_q, s2_q;
	logic [45:0]  prod_q;
	logic [31:0]  prev_q;
	logic [3:0]   prio_q;
	logic [30:0]  x_q;
	logic [4:0]   e_q;
	logic [F-1:0] frac_q;
	logic [RW-1:0] d_q;
	logic [47:0]  plo_q;
	logic [PHW-1:0] phi_q;
	logic [RW-1:0] nl_q;
	logic [GMW-1:0] gm_q;
	logic [31:0]  arr_q;
	logic [46:0]  bt_q;
	logic [15:0]  burst_q;
	logic [3:0]   out_prio_q;
	logic [31:0]  out_arr_q;
	logic [15:0]  out_burst_q;

	logic [31:0]  red_sum;
	logic [30:0]  red_val;
	logic [34:0]  p10;
	logic [31:0]  p10_sum;
	logic [3:0]   p10_q;
	logic [61:0]  sq;
	logic [31:0]  sq_t;
	logic [RW-1:0] r_val;
	logic [SW-1:0] nl_sum;
	logic [GSW-1:0] gs;
	logic [GW-1:0] gap;
	logic [32:0]  arr_sum;
	logic signed [16:0] bdiff;
	logic [15:0]  bmag;
	logic [31:0]  bsum;
	logic [15:0]  bq;

	assign sts.s2_zero = (s2_q == '0);
	assign sts.x_top   = x_q[30];

	assign red_sum = 32'(prod_q[30:0]) + 32'(prod_q[45:31]);
	assign red_val = (red_sum >= 32'(rjag_pkg::PM_MOD)) ?
		31'(red_sum - 32'(rjag_pkg::PM_MOD)) : red_sum[30:0];

	assign p10     = (35'(s1_q) << 3) + (35'(s1_q) << 1);
	assign p10_sum = 32'(p10[34:31]) + 32'(p10[30:0]);
	assign p10_q   = p10[34:31] + ((p10_sum >= 32'(rjag_pkg::PM_MOD)) ? 4'd1 : 4'd0);

	assign sq    = 62'(x_q) * 62'(x_q);
	assign sq_t  = sq[61:30];
	assign r_val = {e_q, frac_q};

	assign nl_sum  = SW'(phi_q) + SW'(plo_q[47:16]);
	assign gs      = GSW'(gm_q) + HALF;
	assign gap     = gs[GSW-1:F];
	assign arr_sum = 33'(prev_q) + 33'(gap);

	assign bdiff = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
	assign bmag  = bdiff[16] ? 16'(-bdiff) : bdiff[15:0];
	assign bsum  = 32'(bt_q[46:31]) + 32'(bt_q[30:0]);
	assign bq    = bt_q[46:31] + ((bsum >= 32'(rjag_pkg::PM_MOD)) ? 16'd1 : 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			max_q  <= '0;
			min_q  <= '0;
			gen_q  <= rjag_pkg::SEED_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					rjag_pkg::REG_MEAN: mean_q <= cfg_data[15:0];
					rjag_pkg::REG_MAX:  max_q  <= cfg_data[15:0];
					rjag_pkg::REG_MIN:  min_q  <= cfg_data[15:0];
					rjag_pkg::REG_SEED: gen_q  <= cfg_data;
					default: ;
				endcase
			end else if (cmd.pm_red) begin
				gen_q <= red_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) prev_q <= previous_arrival;
		if (cmd.pm_mul) prod_q <= 46'(gen_q) * 46'(rjag_pkg::PM_MULT);
		if (cmd.pm_red) begin
			if (cmd.draw == 2'd0) s1_q <= red_val;
			if (cmd.draw == 2'd1) s2_q <= red_val;
		end
		if (cmd.prio) begin
			prio_q <= p10_q + 4'd1;
			x_q    <= s2_q;
			e_q    <= rjag_pkg::EXP_TOP;
		end
		if (cmd.norm && !x_q[30]) begin
			x_q <= {x_q[29:0], 1'b0};
			e_q <= e_q - 5'd1;
		end
		if (cmd.sqr) begin
			if (sq_t[31]) begin
				x_q <= sq_t[31:1];
			end else begin
				x_q <= sq_t[30:0];
			end
			frac_q <= {frac_q[F-2:0], sq_t[31]};
		end
		if (cmd.diff) d_q <= (LM > r_val) ? LM - r_val : '0;
		if (cmd.lnlo) plo_q <= 48'(d_q[15:0]) * 48'(rjag_pkg::LN2_Q32);
		if (cmd.lnhi) phi_q <= PHW'(d_q[RW-1:16]) * PHW'(rjag_pkg::LN2_Q32);
		if (cmd.nl) nl_q <= nl_sum[RW+15:16];
		if (cmd.gap) gm_q <= GMW'(mean_q) * GMW'(nl_q);
		if (cmd.arr) begin
			if (s2_q == '0) begin
				arr_q <= (mean_q != '0) ? 32'hFFFF_FFFF : prev_q;
			end else begin
				arr_q <= arr_sum[32] ? 32'hFFFF_FFFF : arr_sum[31:0];
			end
		end
		if (cmd.bmul) bt_q <= 47'(bmag) * 47'(gen_q);
		if (cmd.bred) burst_q <= bdiff[16] ? (min_q - bq) : (min_q + bq);
		if (cmd.load_out) begin
			out_prio_q  <= prio_q;
			out_arr_q   <= arr_q;
			out_burst_q <= burst_q;
		end
	end

	assign job_priority = out_prio_q;
	assign job_arrival  = out_arr_q;
	assign job_burst    = out_burst_q;

endmodule

// ===== hdl/random_job_attribute_generator.sv =====
// Top level of the random job attribute generator.
// Usage:
//   Input stream (s_*): one transaction per job, carrying the previous arrival time.
//   Output stream (m_*): one transaction per input, with priority, arrival and burst.
//   Config port: cfg_we writes cfg_data into register cfg_addr (0 mean, 1 max burst,
//   2 min burst, 3 seed); a seed write reloads the generator. Write only while idle.
// Sequence:
//   An input takes 3 generator steps (multiply, modular reduce), a priority step,
//   a normalize loop (one shift per cycle), one squaring per fraction bit of the
//   logarithm, the scaling steps (difference, logarithm products, sum, gap, arrival,
//   burst multiply, burst reduce) and a load of the output register. When the second
//   draw is zero, the normalize, logarithm and gap steps are skipped. A new input is
//   accepted only in the idle state, after the previous result has been loaded.
//   The normalize loop and the logarithm loop set the time from acceptance to a result.
// Reset: generator state returns to 56329, mean, max and min burst to zero, no output valid.
// Stall: a finished result waits in the output register; the next input is still
//   accepted and computed, and its result is held until the output register frees.
`timescale 1ns / 1ps
module random_job_attribute_generator #(
	parameter int LN_FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] previous_arrival
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [3:0] job_priority, [35:4] job_arrival, [51:36] job_burst
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [30:0] cfg_data
);

	rjag_pkg::cmd_t cmd;
	rjag_pkg::sts_t sts;
	logic [3:0]  job_priority;
	logic [31:0] job_arrival;
	logic [15:0] job_burst;

	rjag_ctrl #(.LN_FRAC_BITS(LN_FRAC_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rjag_dp #(.LN_FRAC_BITS(LN_FRAC_BITS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_data         (cfg_data),
		.previous_arrival (s_tdata),
		.cmd              (cmd),
		.sts              (sts),
		.job_priority     (job_priority),
		.job_arrival      (job_arrival),
		.job_burst        (job_burst)
	);

	assign m_tdata = {4'b0000, job_burst, job_arrival, job_priority};

	a_prio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] != 4'd0 && m_tdata[3:0] <= 4'd10))
		else $error("priority out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

	a_no_load_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.load_out)
		else $error("output loaded without a job");

endmodule
